// File: design/hop_count_route_table_assert.svh
// Assertion macros used by the route table top level.
`ifndef HOP_COUNT_ROUTE_TABLE_ASSERT_SVH
`define HOP_COUNT_ROUTE_TABLE_ASSERT_SVH

`ifndef ASSERT_OFF
// check that prop holds at every edge outside reset
`define HCTR_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("hop_count_route_table check failed");
// check that cond never holds outside reset
`define HCTR_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("hop_count_route_table forbidden condition");
`else
`define HCTR_ASSERT(label, clk, rst_n, prop)
`define HCTR_NEVER(label, clk, rst_n, cond)
`endif

`endif

// File: design/hctr_pkg.sv
// Types and constants of the hop count route table.
package hctr_pkg;

	localparam int DEF_TABLE_DEPTH = 32;
	localparam int DEF_KEY_BITS    = 16;
	localparam int HOST_W          = 16;
	localparam int HOP_W           = 5;
	localparam int OP_W            = 2;
	localparam int STATUS_W        = 2;

	localparam logic [HOP_W-1:0] HOP_INF = 5'd16;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_FLUSH  = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE = 2'd0,
		ST_DUP  = 2'd1,
		ST_MISS = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FINISH
	} state_t;

	// scan control from the sequencer to the match unit
	typedef struct packed {
		logic start;
		logic issue;
	} scan_ctl_t;

	// accumulated scan outcome back to the sequencer
	typedef struct packed {
		logic             hit;
		logic             free;
		logic [HOP_W-1:0] hit_hops;
	} scan_res_t;

endpackage

// File: design/hop_count_route_table.sv
// Top level of the hop count route table.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | operation, host, hop_count
//  rsp     | out       | rsp_valid/rsp_stall  | status, found_hops, entry_count
//
// Insert, remove and lookup make one memory read per slot over a single read port
// (S_SCAN), wait out the registered read data (S_DRAIN), then write back and load
// the result register (S_FINISH). Flush clears one slot per cycle in S_CLEAR.
// After reset a clearing pass over all TABLE_DEPTH slots runs with req_stall high.
// One item is in work at a time; the next is taken while a result waits in the output
// register, and a stalled result holds the sequencer only at its final cycle.
`include "hop_count_route_table_assert.svh"

module hop_count_route_table import hctr_pkg::*; #(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int KEY_BITS    = DEF_KEY_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  logic [OP_W-1:0]                  operation,
	input  logic [HOST_W-1:0]                host,
	input  logic [HOP_W-1:0]                 hop_count,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output logic [STATUS_W-1:0]              status,
	output logic [HOP_W-1:0]                 found_hops,
	output logic [$clog2(TABLE_DEPTH+1)-1:0] entry_count
);

	localparam int AW    = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int ENT_W = KEY_BITS + HOP_W + 1;

	logic [KEY_BITS-1:0] key;
	scan_ctl_t           scan_ctl;
	scan_res_t           res;
	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic [AW-1:0]       hit_idx;
	logic [AW-1:0]       free_idx;
	logic                we;
	logic [AW-1:0]       waddr;
	logic [ENT_W-1:0]    wdata;
	logic [ENT_W-1:0]    rdata;

	// one entry: valid bit, hop count, key
	hctr_ram #(
		.WIDTH (ENT_W),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	hctr_match #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.KEY_BITS    (KEY_BITS)
	) u_match (
		.clk      (clk),
		.arst_n   (arst_n),
		.scan_ctl (scan_ctl),
		.rd_addr  (rd_addr),
		.key      (key),
		.rdata    (rdata),
		.res      (res),
		.hit_idx  (hit_idx),
		.free_idx (free_idx)
	);

	hctr_ctrl #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.KEY_BITS    (KEY_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.operation   (operation),
		.host        (host),
		.hop_count   (hop_count),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.found_hops  (found_hops),
		.entry_count (entry_count),
		.key         (key),
		.scan_ctl    (scan_ctl),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.res         (res),
		.hit_idx     (hit_idx),
		.free_idx    (free_idx),
		.we          (we),
		.waddr       (waddr),
		.wdata       (wdata)
	);

	`HCTR_ASSERT(a_count_bound, clk, arst_n, rsp_valid |-> (entry_count <= CNT_W'(TABLE_DEPTH)))
	`HCTR_ASSERT(a_full_count, clk, arst_n, (rsp_valid && status == ST_FULL) |-> (entry_count == CNT_W'(TABLE_DEPTH)))
	`HCTR_ASSERT(a_busy_after_accept, clk, arst_n, (req_valid && !req_stall) |=> req_stall)
	`HCTR_NEVER(a_hops_on_fail, clk, arst_n, rsp_valid && status != ST_DONE && found_hops != '0)

endmodule

// File: design/hctr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hctr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: design/hctr_match.sv
// Match unit: compares each scanned entry against the key and tracks the first free slot.
module hctr_match import hctr_pkg::*; #(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int KEY_BITS    = DEF_KEY_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  scan_ctl_t                      scan_ctl,
	input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
	input  logic [KEY_BITS-1:0]            key,
	input  logic [KEY_BITS+HOP_W:0]        rdata,
	output scan_res_t                      res,
	output logic [$clog2(TABLE_DEPTH)-1:0] hit_idx,
	output logic [$clog2(TABLE_DEPTH)-1:0] free_idx
);

	localparam int AW = $clog2(TABLE_DEPTH);

	logic          issue_s1;
	logic [AW-1:0] idx_s1;
	logic          hit_q;
	logic          free_q;
	logic [AW-1:0] hit_idx_q;
	logic [AW-1:0] free_idx_q;
	logic [HOP_W-1:0] hit_hops_q;

	logic                ent_valid;
	logic [HOP_W-1:0]    ent_hops;
	logic [KEY_BITS-1:0] ent_key;
	logic                take_hit;
	logic                take_free;

	assign ent_valid = rdata[KEY_BITS+HOP_W];
	assign ent_hops  = rdata[KEY_BITS +: HOP_W];
	assign ent_key   = rdata[KEY_BITS-1:0];

	assign take_hit  = issue_s1 && !hit_q && ent_valid && (ent_key == key);
	assign take_free = issue_s1 && !free_q && !ent_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= 1'b0;
			hit_q    <= 1'b0;
			free_q   <= 1'b0;
		end else begin
			issue_s1 <= scan_ctl.issue;
			if (scan_ctl.start) begin
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else begin
				if (take_hit) begin
					hit_q <= 1'b1;
				end
				if (take_free) begin
					free_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_addr;
		if (take_hit) begin
			hit_idx_q  <= idx_s1;
			hit_hops_q <= ent_hops;
		end
		if (take_free) begin
			free_idx_q <= idx_s1;
		end
	end

	assign res.hit      = hit_q;
	assign res.free     = free_q;
	assign res.hit_hops = hit_hops_q;
	assign hit_idx      = hit_idx_q;
	assign free_idx     = free_idx_q;

endmodule

// File: design/hctr_ctrl.sv
// Sequencer: accepts items, sweeps the table, writes back and holds the result register.
module hctr_ctrl import hctr_pkg::*; #(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int KEY_BITS    = DEF_KEY_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  logic [OP_W-1:0]                    operation,
	input  logic [HOST_W-1:0]                  host,
	input  logic [HOP_W-1:0]                   hop_count,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output logic [STATUS_W-1:0]                status,
	output logic [HOP_W-1:0]                   found_hops,
	output logic [$clog2(TABLE_DEPTH+1)-1:0]   entry_count,
	output logic [KEY_BITS-1:0]                key,
	output scan_ctl_t                          scan_ctl,
	output logic                               rd_en,
	output logic [$clog2(TABLE_DEPTH)-1:0]     rd_addr,
	input  scan_res_t                          res,
	input  logic [$clog2(TABLE_DEPTH)-1:0]     hit_idx,
	input  logic [$clog2(TABLE_DEPTH)-1:0]     free_idx,
	output logic                               we,
	output logic [$clog2(TABLE_DEPTH)-1:0]     waddr,
	output logic [KEY_BITS+HOP_W:0]            wdata
);

	localparam int AW    = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int ENT_W = KEY_BITS + HOP_W + 1;

	state_t state_q, state_nxt;
	logic                boot_q;
	logic [AW-1:0]       ptr_q;
	op_t                 op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [HOP_W-1:0]    hops_q;
	logic [CNT_W-1:0]    count_q;

	logic                rsp_valid_q;
	status_t             status_q;
	logic [HOP_W-1:0]    found_q;
	logic [CNT_W-1:0]    entry_count_q;

	logic                ptr_last;
	logic                out_free;
	logic                accept;
	logic                finish_fire;
	status_t             res_status;
	logic [HOP_W-1:0]    res_found;
	logic [CNT_W-1:0]    res_count;

	assign ptr_last    = (ptr_q == AW'(TABLE_DEPTH - 1));
	assign out_free    = !rsp_valid_q || !rsp_stall;
	assign accept      = (state_q == S_IDLE) && req_valid;
	assign finish_fire = (state_q == S_FINISH) && out_free;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (ptr_last) begin
					state_nxt = boot_q ? S_IDLE : S_FINISH;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					state_nxt = (op_t'(operation) == OP_FLUSH) ? S_CLEAR : S_SCAN;
				end
			end
			S_SCAN: begin
				if (ptr_last) begin
					state_nxt = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_nxt = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// result of the finished scan
	always_comb begin
		res_status = ST_DONE;
		res_found  = '0;
		res_count  = count_q;
		unique case (op_q)
			OP_INSERT: begin
				if (res.hit) begin
					res_status = ST_DUP;
				end else if (!res.free) begin
					res_status = ST_FULL;
				end else begin
					res_count = count_q + CNT_W'(1);
				end
			end
			OP_REMOVE: begin
				if (res.hit) begin
					res_found = res.hit_hops;
					res_count = count_q - CNT_W'(1);
				end else begin
					res_status = ST_MISS;
				end
			end
			OP_LOOKUP: begin
				if (res.hit) begin
					res_found = res.hit_hops;
				end else begin
					res_status = ST_MISS;
				end
			end
			OP_FLUSH: begin
				res_count = '0;
			end
			default: begin
				res_status = ST_DONE;
			end
		endcase
	end

	// outputs toward the channel, the match unit and the memory
	always_comb begin
		req_stall      = (state_q != S_IDLE);
		scan_ctl.start = accept;
		scan_ctl.issue = (state_q == S_SCAN);
		rd_en          = (state_q == S_SCAN);
		rd_addr        = ptr_q;
		we             = 1'b0;
		waddr          = ptr_q;
		wdata          = '0;
		unique case (state_q)
			S_CLEAR: begin
				we = 1'b1;
			end
			S_FINISH: begin
				if (out_free) begin
					if (op_q == OP_INSERT && !res.hit && res.free) begin
						we    = 1'b1;
						waddr = free_idx;
						wdata = ENT_W'({1'b1, hops_q, key_q});
					end else if (op_q == OP_REMOVE && res.hit) begin
						// drop the entry by clearing its valid bit
						we    = 1'b1;
						waddr = hit_idx;
					end
				end
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			boot_q      <= 1'b1;
			ptr_q       <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == S_CLEAR && ptr_last) begin
				boot_q <= 1'b0;
			end
			if (state_q == S_CLEAR || state_q == S_SCAN) begin
				ptr_q <= ptr_last ? '0 : ptr_q + AW'(1);
			end
			if (finish_fire) begin
				count_q     <= res_count;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op_t'(operation);
			key_q  <= KEY_BITS'(host);
			hops_q <= (hop_count > HOP_INF) ? HOP_INF : hop_count;
		end
		if (finish_fire) begin
			status_q      <= res_status;
			found_q       <= res_found;
			entry_count_q <= res_count;
		end
	end

	assign key         = key_q;
	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign found_hops  = found_q;
	assign entry_count = entry_count_q;

endmodule
